FILE: rtl/dcm_pkg.sv
package dcm_pkg;

   // Quotient bits produced by one divider row (one bit per cell).
   localparam int unsigned QuoBits = 16;
   // Width of divisor and partial remainder in the divider cells.
   localparam int unsigned DenBits = 24;
   localparam int unsigned CoeffBits = 16;
   localparam int unsigned FieldBits = 24;
   localparam int unsigned CsrIndexBits = 3;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexBits-1:0] RegBaseCoeff = 3'd0;
   localparam logic [CsrIndexBits-1:0] RegPeakCoeff = 3'd1;
   localparam logic [CsrIndexBits-1:0] RegRiseStart = 3'd2;
   localparam logic [CsrIndexBits-1:0] RegPeakMach  = 3'd3;
   localparam logic [CsrIndexBits-1:0] RegFallEnd   = 3'd4;

   // Flags that ride along with an item through the pipeline.
   typedef struct packed {
      logic bypass;  // result is the base coefficient
      logic sat;     // Mach quotient saturates
      logic fall;    // item lies on the falling segment
   } side_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic                 valid;
      logic [DenBits-1:0]   rem;
      logic [DenBits-1:0]   den;
      logic [QuoBits-1:0]   num;
      logic [QuoBits-1:0]   quo;
      side_type             side;
   } div_type;

endpackage

FILE: rtl/dcm_div_cell.sv
module dcm_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  dcm_pkg::div_type  cell_in,
   output dcm_pkg::div_type  cell_out
);

   logic [dcm_pkg::DenBits:0] trial;
   logic                      take;
   dcm_pkg::div_type          stage_in;
   dcm_pkg::div_type          stage_ff;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial = {cell_in.rem, cell_in.num[dcm_pkg::QuoBits-1]};
      take  = trial >= {1'b0, cell_in.den};
      stage_in     = cell_in;
      stage_in.rem = take ? dcm_pkg::DenBits'(trial - {1'b0, cell_in.den})
                          : trial[dcm_pkg::DenBits-1:0];
      stage_in.num = {cell_in.num[dcm_pkg::QuoBits-2:0], 1'b0};
      stage_in.quo = {cell_in.quo[dcm_pkg::QuoBits-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule

FILE: rtl/dcm_div_row.sv
module dcm_div_row (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  dcm_pkg::div_type  row_in,
   output dcm_pkg::div_type  row_out
);

   dcm_pkg::div_type links [0:dcm_pkg::QuoBits];

   assign links[0] = row_in;

   // A chain of cells, each resolving one quotient bit per beat.
   for (genvar i = 0; i < dcm_pkg::QuoBits; i++) begin : g_cell
      dcm_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (links[i]),
         .cell_out (links[i+1])
      );
   end

   assign row_out = links[dcm_pkg::QuoBits];

endmodule

FILE: rtl/dcm_blend.sv
module dcm_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  dcm_pkg::div_type                  pos_in,
   input  logic [dcm_pkg::CoeffBits-1:0]     base_coeff,
   input  logic [dcm_pkg::CoeffBits-1:0]     peak_coeff,
   output logic                              res_valid,
   output logic [dcm_pkg::CoeffBits-1:0]     res_value
);

   logic              a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   dcm_pkg::side_type a_side_ff, b_side_ff, c_side_ff, d_side_ff;
   logic [15:0]       a_t_ff;
   logic [31:0]       a_t2_ff, b_t2_ff;
   logic [47:0]       b_t3_ff;
   logic [15:0]       c_s_ff, c_diff_ff;
   logic              c_up_ff, d_up_ff;
   logic [31:0]       d_prod_ff;

   logic [49:0]       poly;
   logic [15:0]       coeff_a, coeff_b, c_s_in, c_diff_in, d_part;
   logic              c_up_in;

   // Smoothstep 3t^2 - 2t^3 and the direction of the blend.
   always_comb begin
      poly = {1'b0, b_t2_ff, 17'b0} + {2'b0, b_t2_ff, 16'b0} - {1'b0, b_t3_ff, 1'b0};
      c_s_in = poly[47:32];
      coeff_a = b_side_ff.fall ? peak_coeff : base_coeff;
      coeff_b = b_side_ff.fall ? base_coeff : peak_coeff;
      c_up_in = coeff_b >= coeff_a;
      c_diff_in = c_up_in ? coeff_b - coeff_a : coeff_a - coeff_b;
   end

   // Valid bits of the four stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= pos_in.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   // Payload: square, cube, smoothstep, product.
   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= pos_in.side;
         a_t_ff    <= pos_in.quo;
         a_t2_ff   <= pos_in.quo * pos_in.quo;
         b_side_ff <= a_side_ff;
         b_t2_ff   <= a_t2_ff;
         b_t3_ff   <= a_t2_ff * a_t_ff;
         c_side_ff <= b_side_ff;
         c_s_ff    <= c_s_in;
         c_diff_ff <= c_diff_in;
         c_up_ff   <= c_up_in;
         d_side_ff <= c_side_ff;
         d_up_ff   <= c_up_ff;
         d_prod_ff <= c_diff_ff * c_s_ff;
      end
   end

   // Final add or subtract from the segment's starting coefficient; bypass items take the base coefficient.
   always_comb begin
      d_part = d_prod_ff[31:16];
      if (d_side_ff.bypass) begin
         res_value = base_coeff;
      end else if (d_up_ff) begin
         res_value = (d_side_ff.fall ? peak_coeff : base_coeff) + d_part;
      end else begin
         res_value = (d_side_ff.fall ? peak_coeff : base_coeff) - d_part;
      end
   end

   assign res_valid = d_valid_ff;

endmodule

FILE: rtl/drag_coefficient_mach_curve_core.sv
// A request beat passes 16 Mach divider cells, segment select, 16 position
// divider cells, 4 blend stages and the output register. Throughput: one
// beat per cycle unless a result is stuck at the output, set by the two
// chains of divider cells that each take a new item every unstalled cycle.
// Reset clears all valid bits and loads the default coefficients and knees.
module drag_coefficient_mach_curve_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // speed [23:0], sound_speed [47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drag_coeff [15:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] base_ff, peak_ff, rise_ff, pmach_ff, fend_ff;

   logic [23:0]      speed, sound;
   dcm_pkg::div_type mach_in, mach_out, seg_in, seg_ff, pos_out;
   logic [15:0]      mach, lo, hi;
   logic             en, last_valid, out_load;
   logic [15:0]      last_value;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_data_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 16'd819;
         peak_ff  <= 16'd2048;
         rise_ff  <= 16'd2867;
         pmach_ff <= 16'd5325;
         fend_ff  <= 16'd14336;
      end else if (csr_valid) begin
         unique case (csr_index)
            dcm_pkg::RegBaseCoeff: base_ff  <= csr_data;
            dcm_pkg::RegPeakCoeff: peak_ff  <= csr_data;
            dcm_pkg::RegRiseStart: rise_ff  <= csr_data;
            dcm_pkg::RegPeakMach:  pmach_ff <= csr_data;
            dcm_pkg::RegFallEnd:   fend_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves unless a finished result is stuck at the output.
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign en         = out_load || !last_valid;
   assign req_tready = en;

   // Mach divider setup: (speed << 12) / sound_speed, first 20 bits preloaded.
   always_comb begin
      speed = req_tdata[23:0];
      sound = req_tdata[47:24];
      mach_in.valid       = req_tvalid;
      mach_in.rem         = {4'b0, speed[23:4]};
      mach_in.den         = sound;
      mach_in.num         = {speed[3:0], 12'b0};
      mach_in.quo         = '0;
      mach_in.side.bypass = sound == '0;
      mach_in.side.sat    = {4'b0, speed} >= {sound, 4'b0};
      mach_in.side.fall   = 1'b0;
   end

   dcm_div_row u_mach_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .row_in  (mach_in),
      .row_out (mach_out)
   );

   // Segment select and setup of the position divider.
   always_comb begin
      mach = mach_out.side.sat ? 16'hFFFF : mach_out.quo;
      seg_in      = mach_out;
      seg_in.side.sat = 1'b0;
      lo = rise_ff;
      hi = pmach_ff;
      priority if (mach_out.side.bypass || mach < rise_ff) begin
         seg_in.side.bypass = 1'b1;
         seg_in.side.fall   = 1'b0;
      end else if (mach < pmach_ff) begin
         seg_in.side.fall   = 1'b0;
      end else if (mach < fend_ff) begin
         lo = pmach_ff;
         hi = fend_ff;
         seg_in.side.fall   = 1'b1;
      end else begin
         seg_in.side.bypass = 1'b1;
         seg_in.side.fall   = 1'b0;
      end
      seg_in.rem = {8'b0, 16'(mach - lo)};
      seg_in.den = {8'b0, 16'(hi - lo)};
      seg_in.num = '0;
      seg_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff.valid <= 1'b0;
      end else if (en) begin
         seg_ff <= seg_in;
      end
   end

   dcm_div_row u_pos_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .row_in  (seg_ff),
      .row_out (pos_out)
   );

   dcm_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .pos_in     (pos_out),
      .base_coeff (base_ff),
      .peak_coeff (peak_ff),
      .res_valid  (last_valid),
      .res_value  (last_value)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= last_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
